// ----- design/ecseq_pkg.sv -----
// Shared types and codes for the embedded controller host transaction sequencer.
// Holds the request and result payload structs, the phase encoding and the codes.
// No dependencies.
package ecseq_pkg;

  // Request actions
  localparam logic [2:0] ACT_READ      = 3'd0;
  localparam logic [2:0] ACT_WRITE     = 3'd1;
  localparam logic [2:0] ACT_BURST_ON  = 3'd2;
  localparam logic [2:0] ACT_BURST_OFF = 3'd3;
  localparam logic [2:0] ACT_QUERY     = 3'd4;
  localparam logic [2:0] ACT_CHECK     = 3'd5;
  localparam logic [2:0] ACT_PORT_BYTE = 3'd6;
  localparam logic [2:0] ACT_TICK      = 3'd7;

  // Result access kinds
  localparam logic [2:0] KIND_READ_STATUS = 3'd0;
  localparam logic [2:0] KIND_READ_DATA   = 3'd1;
  localparam logic [2:0] KIND_WRITE_CMD   = 3'd2;
  localparam logic [2:0] KIND_WRITE_DATA  = 3'd3;
  localparam logic [2:0] KIND_WAIT        = 3'd4;
  localparam logic [2:0] KIND_DONE        = 3'd5;

  // Outcomes on done
  localparam logic [1:0] OUT_OK      = 2'd0;
  localparam logic [1:0] OUT_TIMEOUT = 2'd1;
  localparam logic [1:0] OUT_BUSY    = 2'd2;

  // Controller command codes
  localparam logic [7:0] CMD_READ      = 8'h80;
  localparam logic [7:0] CMD_WRITE     = 8'h81;
  localparam logic [7:0] CMD_BURST_ON  = 8'h82;
  localparam logic [7:0] CMD_BURST_OFF = 8'h83;
  localparam logic [7:0] CMD_QUERY     = 8'h84;

  // Status flags
  localparam logic [7:0] FLAG_OBF     = 8'h01;
  localparam logic [7:0] FLAG_IBF     = 8'h02;
  localparam logic [7:0] FLAG_SCI_EVT = 8'h20;

  localparam logic [15:0] POLL_LIMIT_RESET = 16'd1000;

  typedef enum logic [8:0] {
    PH_IDLE  = 9'b000000001,
    PH_POLL0 = 9'b000000010,
    PH_TICK0 = 9'b000000100,
    PH_POLL1 = 9'b000001000,
    PH_TICK1 = 9'b000010000,
    PH_POLL2 = 9'b000100000,
    PH_TICK2 = 9'b001000000,
    PH_DATA  = 9'b010000000,
    PH_SCI   = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] address;
    logic [7:0] value;
    logic [7:0] port_byte;
  } req_t;

  typedef struct packed {
    logic [2:0] access_kind;
    logic [7:0] access_byte;
    logic [1:0] outcome;
    logic       last;
  } rsp_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  operation;
    logic [7:0]  saved_address;
    logic [7:0]  saved_value;
    logic [15:0] polls_left;
  } seq_state_t;

  typedef struct packed {
    seq_state_t nxt;
    logic [1:0] count;
    rsp_t       r0;
    rsp_t       r1;
  } step_out_t;

  function automatic rsp_t mk_rsp(logic [2:0] kind, logic [7:0] byte_val,
                                  logic [1:0] outc);
    rsp_t r;
    r.access_kind = kind;
    r.access_byte = byte_val;
    r.outcome     = outc;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] cmd_of(logic [2:0] op);
    logic [7:0] c;
    case (op)
      ACT_READ:      c = CMD_READ;
      ACT_WRITE:     c = CMD_WRITE;
      ACT_BURST_ON:  c = CMD_BURST_ON;
      ACT_BURST_OFF: c = CMD_BURST_OFF;
      ACT_QUERY:     c = CMD_QUERY;
      ACT_CHECK:     c = CMD_READ;
      default:       c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- design/ecseq_step.sv -----
// Next-state and result logic for one request of the transaction sequencer.
// Purely combinational; uses ecseq_pkg types, codes and helper functions.
module ecseq_step (
  input  ecseq_pkg::seq_state_t cur,
  input  logic [15:0]           poll_limit,
  input  ecseq_pkg::req_t       req,
  output ecseq_pkg::step_out_t  res
);
  import ecseq_pkg::*;

  logic [1:0] stage;
  logic       obf_wait;
  logic       flag_ok;
  logic       op_rwc;
  logic       op_bq;
  step_out_t  s;

  assign op_rwc = (cur.operation == ACT_READ) || (cur.operation == ACT_WRITE) ||
                  (cur.operation == ACT_CHECK);
  assign op_bq  = (cur.operation == ACT_BURST_ON) || (cur.operation == ACT_QUERY);

  always_comb begin
    case (cur.phase)
      PH_POLL1: stage = 2'd1;
      PH_POLL2: stage = 2'd2;
      default:  stage = 2'd0;
    endcase
    case (stage)
      2'd1:    obf_wait = op_bq;
      2'd2:    obf_wait = (cur.operation == ACT_READ) || (cur.operation == ACT_CHECK);
      default: obf_wait = 1'b0;
    endcase
    flag_ok = obf_wait ? ((req.port_byte & FLAG_OBF) != 8'h00)
                       : ((req.port_byte & FLAG_IBF) == 8'h00);
  end

  always_comb begin
    s       = '0;
    s.nxt   = cur;
    s.count = 2'd0;
    if (req.action inside {[ACT_READ:ACT_CHECK]}) begin
      s.count = 2'd1;
      if (cur.phase != PH_IDLE) begin
        s.r0 = mk_rsp(KIND_DONE, 8'h00, OUT_BUSY);
      end else begin
        s.nxt.operation     = req.action;
        s.nxt.saved_address = req.address;
        s.nxt.saved_value   = req.value;
        s.r0                = mk_rsp(KIND_READ_STATUS, 8'h00, OUT_OK);
        if (req.action == ACT_QUERY) begin
          s.nxt.phase = PH_SCI;
        end else begin
          s.nxt.phase      = PH_POLL0;
          s.nxt.polls_left = poll_limit;
        end
      end
    end else if (req.action == ACT_PORT_BYTE) begin
      case (cur.phase)
        PH_SCI: begin
          s.count = 2'd1;
          if ((req.port_byte & FLAG_SCI_EVT) == 8'h00) begin
            s.nxt.phase = PH_IDLE;
            s.r0        = mk_rsp(KIND_DONE, 8'h00, OUT_OK);
          end else begin
            s.nxt.phase      = PH_POLL0;
            s.nxt.polls_left = poll_limit;
            s.r0             = mk_rsp(KIND_READ_STATUS, 8'h00, OUT_OK);
          end
        end
        PH_DATA: begin
          s.count     = 2'd1;
          s.nxt.phase = PH_IDLE;
          // keep the data byte only for read and query
          if ((cur.operation == ACT_READ) || (cur.operation == ACT_QUERY)) begin
            s.r0 = mk_rsp(KIND_DONE, req.port_byte, OUT_OK);
          end else begin
            s.r0 = mk_rsp(KIND_DONE, 8'h00, OUT_OK);
          end
        end
        PH_POLL0, PH_POLL1, PH_POLL2: begin
          if (flag_ok) begin
            case (stage)
              2'd0: begin
                if (cur.operation inside {[ACT_READ:ACT_CHECK]}) begin
                  s.count          = 2'd2;
                  s.r0             = mk_rsp(KIND_WRITE_CMD, cmd_of(cur.operation), OUT_OK);
                  s.r1             = mk_rsp(KIND_READ_STATUS, 8'h00, OUT_OK);
                  s.nxt.phase      = PH_POLL1;
                  s.nxt.polls_left = poll_limit;
                end else begin
                  s.count     = 2'd1;
                  s.r0        = mk_rsp(KIND_DONE, 8'h00, OUT_OK);
                  s.nxt.phase = PH_IDLE;
                end
              end
              2'd1: begin
                if (op_rwc) begin
                  s.count = 2'd2;
                  s.r0    = mk_rsp(KIND_WRITE_DATA,
                                   (cur.operation == ACT_CHECK) ? 8'h00 : cur.saved_address,
                                   OUT_OK);
                  s.r1             = mk_rsp(KIND_READ_STATUS, 8'h00, OUT_OK);
                  s.nxt.phase      = PH_POLL2;
                  s.nxt.polls_left = poll_limit;
                end else if (op_bq) begin
                  s.count     = 2'd1;
                  s.r0        = mk_rsp(KIND_READ_DATA, 8'h00, OUT_OK);
                  s.nxt.phase = PH_DATA;
                end else begin
                  s.count     = 2'd1;
                  s.r0        = mk_rsp(KIND_DONE, 8'h00, OUT_OK);
                  s.nxt.phase = PH_IDLE;
                end
              end
              default: begin
                if (cur.operation == ACT_WRITE) begin
                  s.count     = 2'd2;
                  s.r0        = mk_rsp(KIND_WRITE_DATA, cur.saved_value, OUT_OK);
                  s.r1        = mk_rsp(KIND_DONE, 8'h00, OUT_OK);
                  s.nxt.phase = PH_IDLE;
                end else if ((cur.operation == ACT_READ) ||
                             (cur.operation == ACT_CHECK)) begin
                  s.count     = 2'd1;
                  s.r0        = mk_rsp(KIND_READ_DATA, 8'h00, OUT_OK);
                  s.nxt.phase = PH_DATA;
                end else begin
                  s.count     = 2'd1;
                  s.r0        = mk_rsp(KIND_DONE, 8'h00, OUT_OK);
                  s.nxt.phase = PH_IDLE;
                end
              end
            endcase
          end else if (cur.polls_left == 16'd0) begin
            s.count     = 2'd1;
            s.r0        = mk_rsp(KIND_DONE, 8'h00, OUT_TIMEOUT);
            s.nxt.phase = PH_IDLE;
          end else begin
            s.count          = 2'd1;
            s.r0             = mk_rsp(KIND_WAIT, 8'h00, OUT_OK);
            s.nxt.polls_left = cur.polls_left - 16'd1;
            case (cur.phase)
              PH_POLL1: s.nxt.phase = PH_TICK1;
              PH_POLL2: s.nxt.phase = PH_TICK2;
              default:  s.nxt.phase = PH_TICK0;
            endcase
          end
        end
        default: ;
      endcase
    end else begin
      // tick: re-read status only when a wait is pending
      case (cur.phase)
        PH_TICK0: begin
          s.count     = 2'd1;
          s.nxt.phase = PH_POLL0;
          s.r0        = mk_rsp(KIND_READ_STATUS, 8'h00, OUT_OK);
        end
        PH_TICK1: begin
          s.count     = 2'd1;
          s.nxt.phase = PH_POLL1;
          s.r0        = mk_rsp(KIND_READ_STATUS, 8'h00, OUT_OK);
        end
        PH_TICK2: begin
          s.count     = 2'd1;
          s.nxt.phase = PH_POLL2;
          s.r0        = mk_rsp(KIND_READ_STATUS, 8'h00, OUT_OK);
        end
        default: ;
      endcase
    end
    s.r0.last = (s.count == 2'd1);
    s.r1.last = (s.count == 2'd2);
  end

  assign res = s;

endmodule

// ----- design/ecseq_out_buf.sv -----
// Two-slot result buffer: takes one or two results at once, hands them out in order.
// Uses ecseq_pkg for the result payload type.
module ecseq_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [1:0]        count,
  input  ecseq_pkg::rsp_t   r0,
  input  ecseq_pkg::rsp_t   r1,
  output logic              can_load,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ecseq_pkg::rsp_t   rsp
);
  import ecseq_pkg::*;

  rsp_t       slot0;
  rsp_t       slot1;
  logic [1:0] cnt;
  logic       pop;

  assign pop       = (cnt != 2'd0) && !rsp_stall;
  assign can_load  = (cnt == 2'd0) || ((cnt == 2'd1) && pop);
  assign rsp_valid = (cnt != 2'd0);
  assign rsp       = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load && (count != 2'd0)) begin
      cnt <= count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && (count != 2'd0)) begin
      slot0 <= r0;
      slot1 <= r1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

// ----- design/ec_host_transaction_sequencer_unit.sv -----
// Top level of the embedded controller host transaction sequencer.
// Depends on ecseq_pkg, ecseq_step and ecseq_out_buf.
//
//   channel | signals                     | direction | payload
//   --------+-----------------------------+-----------+------------------------
//   req     | req_valid, req_stall, req   | in        | action/address/value/port_byte
//   rsp     | rsp_valid, rsp_stall, rsp   | out       | access_kind/access_byte/outcome/last
//   cfg     | cfg_valid, cfg_ready, cfg_data | in     | poll_limit (16 bits)
//
// One request per cycle unless req stalls; a taken request waits in the input register
// until it fires into the result buffer. rsp hands out one result per cycle unless it
// stalls, so a request with two results holds the two-slot result buffer until both leave.
// rst clears the phase to idle, the saved fields to zero and poll_limit to 1000.
// A stall on rsp holds the buffer; req stalls only while the input register cannot advance.
module ec_host_transaction_sequencer_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  ecseq_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output ecseq_pkg::rsp_t  rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [15:0]      cfg_data
);
  import ecseq_pkg::*;

  logic        req_vld;
  req_t        req_q;
  seq_state_t  state;
  logic [15:0] poll_limit;
  step_out_t   step;
  logic        can_load;
  logic        fire;
  logic        take;

  assign cfg_ready = 1'b1;
  assign fire      = req_vld && ((step.count == 2'd0) || can_load);
  assign req_stall = req_vld && !fire;
  assign take      = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_limit <= POLL_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      poll_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_vld <= 1'b0;
    end else if (take) begin
      req_vld <= 1'b1;
    end else if (fire) begin
      req_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_q <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= PH_IDLE;
      state.operation     <= 3'd0;
      state.saved_address <= 8'h00;
      state.saved_value   <= 8'h00;
      state.polls_left    <= 16'd0;
    end else if (fire) begin
      state <= step.nxt;
    end
  end

  ecseq_step u_step (
    .cur        (state),
    .poll_limit (poll_limit),
    .req        (req_q),
    .res        (step)
  );

  ecseq_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .count     (step.count),
    .r0        (step.r0),
    .r1        (step.r1),
    .can_load  (can_load),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ----- design/ecseq_checker.sv -----
// Port-level checks for the transaction sequencer, bound to the top level.
// Depends on ecseq_pkg for the result payload codes.
module ecseq_checker (
  input logic            clk,
  input logic            rst,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input ecseq_pkg::rsp_t rsp
);
  import ecseq_pkg::*;

  // hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result dropped or changed while stalled");

  a_outcome_on_done: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.outcome != OUT_OK) |-> (rsp.access_kind == KIND_DONE))
    else $error("non-ok outcome on an access other than done");

  a_wait_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.access_kind == KIND_WAIT) |-> rsp.last)
    else $error("wait tick not the final result of its request");

  a_cmd_not_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.access_kind == KIND_WRITE_CMD) |-> !rsp.last)
    else $error("command write not followed by a status read");

  // a result that is not last is followed by one of the same request
  a_pair_follows: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && !rsp.last |=> rsp_valid)
    else $error("second result of a request missing");

endmodule

bind ec_host_transaction_sequencer_unit ecseq_checker u_ecseq_checker (.*);
